FILE: sv/ued_pkg.sv
// ----------------------------------------------------------------------------
// ued_pkg
// Shared types, character codes and hex helpers for the percent decoder.
// ----------------------------------------------------------------------------
package ued_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // What the front end holds back between bytes
  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_PCT,
    PEND_DIGIT
  } pend_t;

  // Up to three output bytes produced by one input byte
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // 'a'/'A' have low nibble 1
      v = c[3:0] + 4'd9;
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

endpackage

FILE: sv/ued_in_if.sv
// ----------------------------------------------------------------------------
// ued_in_if
// Encoded byte stream channel: valid/ready with byte and end-of-message flag.
// ----------------------------------------------------------------------------
interface ued_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: sv/ued_out_if.sv
// ----------------------------------------------------------------------------
// ued_out_if
// Decoded byte stream channel: valid/ready with byte and end-of-message flag.
// ----------------------------------------------------------------------------
interface ued_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: sv/ued_front.sv
// ----------------------------------------------------------------------------
// ued_front
// Accepts encoded bytes, tracks escape state and builds output commands.
// ----------------------------------------------------------------------------
module ued_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         plus_as_space,
  ued_in_if.sink       in_if,
  input  logic         q_full,
  output logic         push,
  output ued_pkg::cmd_t push_cmd
);
  import ued_pkg::*;

  pend_t      pend_r, pend_nxt, pend_step;
  logic [7:0] held_r, held_nxt;
  logic       accept;
  logic       hex;
  logic [3:0] val;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;
  assign hex         = is_hex(in_if.in_byte);
  assign val         = hex_val(in_if.in_byte);

  // Next state
  always_comb begin
    case (pend_r)
      PEND_PCT: begin
        if (hex) pend_step = PEND_DIGIT;
        else     pend_step = (in_if.in_byte == PCT_CHAR) ? PEND_PCT : PEND_NONE;
      end
      default: begin
        if (pend_r == PEND_DIGIT && hex) pend_step = PEND_NONE;
        else pend_step = (in_if.in_byte == PCT_CHAR) ? PEND_PCT : PEND_NONE;
      end
    endcase
    pend_nxt = in_if.in_last ? PEND_NONE : pend_step;
    held_nxt = (pend_r == PEND_PCT && hex) ? in_if.in_byte : held_r;
  end

  // Output command
  always_comb begin
    logic [2:0][7:0] b;
    logic [1:0]      n;
    logic            run_idle;
    b        = '0;
    n        = 2'd0;
    run_idle = 1'b0;
    case (pend_r)
      PEND_PCT: begin
        if (!hex) begin
          b[n] = PCT_CHAR;
          n    = n + 2'd1;
          run_idle = 1'b1;
        end
      end
      PEND_DIGIT: begin
        if (hex) begin
          b[n] = {hex_val(held_r), val};
          n    = n + 2'd1;
        end else begin
          b[n] = PCT_CHAR;
          n    = n + 2'd1;
          b[n] = held_r;
          n    = n + 2'd1;
          run_idle = 1'b1;
        end
      end
      default: run_idle = 1'b1;
    endcase
    if (run_idle && in_if.in_byte != PCT_CHAR) begin
      b[n] = (plus_as_space && in_if.in_byte == PLUS_CHAR) ? SPACE_CHAR : in_if.in_byte;
      n    = n + 2'd1;
    end
    // flush whatever is still held at end of message
    if (in_if.in_last && pend_step != PEND_NONE) begin
      b[n] = PCT_CHAR;
      n    = n + 2'd1;
      if (pend_step == PEND_DIGIT) begin
        b[n] = in_if.in_byte;
        n    = n + 2'd1;
      end
    end
    push_cmd.bytes = b;
    push_cmd.cnt   = n;
    push_cmd.last  = in_if.in_last;
    push           = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_NONE;
    end else if (accept) begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

FILE: sv/ued_queue.sv
// ----------------------------------------------------------------------------
// ued_queue
// Small command queue between the front end and the output sequencer.
// ----------------------------------------------------------------------------
module ued_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ued_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output ued_pkg::cmd_t head
);
  import ued_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full       = (count_r == QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: sv/ued_back.sv
// ----------------------------------------------------------------------------
// ued_back
// Steps through queued commands, one decoded byte per cycle while the receiver
// is ready, into the output register.
// ----------------------------------------------------------------------------
module ued_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  ued_pkg::cmd_t head,
  output logic          pop,
  ued_out_if.source     out_if
);
  import ued_pkg::*;

  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       load;
  logic       at_end;

  assign load   = head_valid && (!out_valid_r || out_if.ready);
  assign at_end = (idx_r == head.cnt - 2'd1);
  assign pop    = load && at_end;

  assign out_if.valid    = out_valid_r;
  assign out_if.out_byte = out_byte_r;
  assign out_if.out_last = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        // advance within the command, rewind on its last byte
        idx_r       <= at_end ? 2'd0 : idx_r + 2'd1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= head.bytes[idx_r];
      out_last_r <= head.last && at_end;
    end
  end

endmodule

FILE: sv/url_percent_decoder_core.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_core
// Streaming URL percent decoder with optional plus-to-space translation.
//
//   channel   dir   handshake      payload
//   in_if     in    valid/ready    in_byte[7:0], in_last
//   out_if    out   valid/ready    out_byte[7:0], out_last
//   cfg_*     in    cfg_we         cfg_wdata = plus_as_space
//
// An input byte is taken every cycle while the command queue has room; it
// turns into zero to three decoded bytes. The output sequencer drives one
// decoded byte per cycle from the queue while the receiver is ready, so the
// sustained rate is one byte per cycle, with the input stalling only while
// the 4-entry queue is full. The first decoded byte passes the command queue
// and then the output register before it is offered on out_if.
// Reset (rst_n low, synchronous) empties the queue, drops held escape bytes
// and sets plus_as_space.
// ----------------------------------------------------------------------------
module url_percent_decoder_core (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  ued_in_if.sink    in_if,
  ued_out_if.source out_if
);
  import ued_pkg::*;

  logic plus_as_space_r;
  logic push, q_full, pop, head_valid;
  cmd_t push_cmd, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plus_as_space_r <= 1'b1;
    end else if (cfg_we) begin
      plus_as_space_r <= cfg_wdata;
    end
  end

  ued_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .plus_as_space (plus_as_space_r),
    .in_if         (in_if),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  ued_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ued_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_if     (out_if)
  );

endmodule

FILE: test/url_percent_decoder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_percent_decoder_core_tb
// Self-checking bench for the streaming percent decoder. Encoded messages go in
// through the input channel. A local decoder model predicts every decoded byte
// and its end flag, and each output transfer is checked against the oldest
// prediction. Directed escapes and a plus-off check come first, then random
// messages under several sender and receiver idling patterns, random plus mode.
// ----------------------------------------------------------------------------
module url_percent_decoder_core_tb;
  import ued_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 55;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       rx_ready  = 1'b0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int cycles         = 0;

  // Decoder model state
  pend_t      model_pend  = PEND_NONE;
  logic [7:0] model_held  = 8'h00;
  logic       model_plus  = 1'b1;

  dec_byte_t  expected_bytes[$];
  logic [7:0] msg_bytes[$];

  ued_in_if  in_ch();
  ued_out_if out_ch();

  assign in_ch.valid   = in_valid;
  assign in_ch.in_byte = in_byte;
  assign in_ch.in_last = in_last;
  assign out_ch.ready  = rx_ready;

  url_percent_decoder_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    rx_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    dec_byte_t exp_b;
    if (rst_n && out_ch.valid && rx_ready) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected output: byte=%02h last=%0b",
                   out_ch.out_byte, out_ch.out_last);
      end else begin
        exp_b = expected_bytes.pop_front();
        if (out_ch.out_byte !== exp_b.data || out_ch.out_last !== exp_b.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected byte=%02h last=%0b, actual byte=%02h last=%0b",
                     exp_b.data, exp_b.last, out_ch.out_byte, out_ch.out_last);
        end
      end
    end
  end

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(21);
    if (r < 10) return 8'h30 + r[7:0];
    if (r < 16) return 8'h61 + r[7:0] - 8'd10;
    return 8'h41 + r[7:0] - 8'd16;
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (hex_digit(b) >= 0) b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic add_msg_byte(input logic [7:0] b);
    msg_bytes = {msg_bytes, b};
  endtask

  // Advance the decoder model by one accepted byte and queue what it emits
  task automatic predict_decode(input logic [7:0] b, input logic lst);
    logic [7:0] outs[3];
    int         n;
    int         v;
    int         h;
    logic       fresh;
    dec_byte_t  e;
    n = 0;
    fresh = 1'b0;
    v = hex_digit(b);
    case (model_pend)
      PEND_PCT: begin
        if (v >= 0) begin
          model_held = b;
          model_pend = PEND_DIGIT;
        end else begin
          outs[n] = PCT_CHAR;
          n = n + 1;
          model_pend = PEND_NONE;
          fresh = 1'b1;
        end
      end
      PEND_DIGIT: begin
        if (v >= 0) begin
          h = hex_digit(model_held);
          if (h < 0) h = 0;
          outs[n] = {h[3:0], v[3:0]};
          n = n + 1;
        end else begin
          outs[n] = PCT_CHAR;
          n = n + 1;
          outs[n] = model_held;
          n = n + 1;
          fresh = 1'b1;
        end
        model_pend = PEND_NONE;
        model_held = 8'h00;
      end
      default: begin
        model_pend = PEND_NONE;
        fresh = 1'b1;
      end
    endcase
    // A breaking byte is handled as if no escape had been open
    if (fresh) begin
      if (b == PCT_CHAR) begin
        model_pend = PEND_PCT;
      end else if (b == PLUS_CHAR && model_plus) begin
        outs[n] = SPACE_CHAR;
        n = n + 1;
      end else begin
        outs[n] = b;
        n = n + 1;
      end
    end
    if (lst) begin
      if (model_pend != PEND_NONE && n < 3) begin
        outs[n] = PCT_CHAR;
        n = n + 1;
      end
      if (model_pend == PEND_DIGIT && n < 3) begin
        outs[n] = model_held;
        n = n + 1;
      end
      model_pend = PEND_NONE;
      model_held = 8'h00;
    end
    for (int i = 0; i < n; i++) begin
      e.data = outs[i];
      e.last = lst && (i == n - 1);
      expected_bytes = {expected_bytes, e};
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_decode(b, lst);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    // An open escape makes no output, so give the pipeline time to settle
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_plus(input logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_plus = v;
  endtask

  // Build one random message into msg_bytes, often well-formed escapes
  task automatic build_message();
    int tokens;
    int r;
    msg_bytes.delete();
    tokens = $urandom_range(6, 1);
    for (int t = 0; t < tokens; t++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        add_msg_byte(PCT_CHAR);
        add_msg_byte(rand_hex_char());
        add_msg_byte(rand_hex_char());
      end else if (r < 55) begin
        add_msg_byte(8'($urandom_range(8'h7E, 8'h20)));
      end else if (r < 65) begin
        add_msg_byte(PLUS_CHAR);
      end else if (r < 75) begin
        add_msg_byte(8'($urandom_range(255)));
      end else if (r < 85) begin
        add_msg_byte(PCT_CHAR);
        if ($urandom_range(1)) add_msg_byte(rand_hex_char());
        add_msg_byte(rand_non_hex());
      end else if (r < 92) begin
        add_msg_byte(PCT_CHAR);
      end else begin
        add_msg_byte(PCT_CHAR);
        add_msg_byte(rand_hex_char());
      end
    end
  endtask

  task automatic test_escapes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_plus(1'b1);
    send_text("%6a%FF");
    send_text("%00");
    send_text("+");
    send_text("%G1");
    send_text("%4Z");
    send_text("%4%41");
    send_text("%4+");
    send_text("%");
    send_text("%4");
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_plus_off();
    write_plus(1'b0);
    send_text("+%+");
    wait_drained();
    write_plus(1'b1);
  endtask

  task automatic test_random_stream();
    int idle_set[4];
    int stall_set[4];
    int sent;
    idle_set  = '{0, 67, 0, 12};
    stall_set = '{0, 0, 67, 12};
    for (int p = 0; p < 4; p++) begin
      write_plus(1'($urandom_range(1)));
      send_idle_pct  = idle_set[p];
      recv_stall_pct = stall_set[p];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_message();
        for (int i = 0; i < msg_bytes.size(); i++)
          send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        sent += msg_bytes.size();
      end
      wait_drained();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_escapes();
    test_plus_off();
    test_random_stream();
    wait_drained();
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
